// ----- design/hket_pkg.sv -----
// ----------------------------------------------------------------------------
// hket_pkg
// Shared types and constants for the HID key event tracker: request and
// result payloads, request codes, event flag bits and controller commands.
// ----------------------------------------------------------------------------
package hket_pkg;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_EVENT_MASK = 2'd0;

  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_ACK    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
  localparam logic [15:0] PAGE_CONSUMER = 16'h000C;

  localparam logic [7:0] EV_KEY_DOWN  = 8'h01;
  localparam logic [7:0] EV_KEY_UP    = 8'h02;
  localparam logic [7:0] EV_CONS_DOWN = 8'h04;
  localparam logic [7:0] EV_CONS_UP   = 8'h08;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] hid_page;
    logic [15:0] hid_code;
    logic        key_down;
    logic [7:0]  ack_bits;
    logic        up_on_clear;
  } hket_req_t;

  typedef struct packed {
    logic [7:0] event_flags;
    logic       irq_set;
    logic       state_changed;
    logic       any_key_held;
    logic       any_consumer_held;
  } hket_res_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
  } hket_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } hket_state_t;

endpackage

// ----- design/hket_ctrl.sv -----
// ----------------------------------------------------------------------------
// hket_ctrl
// Sequencer for one request: capture, key bit read, then update and result.
// ----------------------------------------------------------------------------
module hket_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output hket_pkg::hket_cmd_t  cmd
);
  import hket_pkg::*;

  hket_state_t state;
  hket_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.read    = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_READ:   cmd.read = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

// ----- design/hket_dpath.sv -----
// ----------------------------------------------------------------------------
// hket_dpath
// Key bitmap memory with per-entry valid bits, held-key counters, sticky
// event flags and the registered result.
// ----------------------------------------------------------------------------
module hket_dpath #(
  parameter int USAGES_PER_PAGE = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hket_pkg::hket_cmd_t  cmd,
  input  hket_pkg::hket_req_t  req,
  input  logic [7:0]           event_mask,
  output logic                 done,
  output hket_pkg::hket_res_t  result
);
  import hket_pkg::*;

  localparam int IDW   = $clog2(USAGES_PER_PAGE);
  localparam int DEPTH = USAGES_PER_PAGE;
  localparam int CW    = $clog2(USAGES_PER_PAGE + 1);

  hket_req_t         req_q;
  // Each entry holds the keyboard bit (bit 0) and the consumer bit (bit 1)
  // of one usage id.
  logic [1:0]        key_ram [DEPTH];
  logic [DEPTH-1:0]  key_valid;
  logic [1:0]        key_rd;
  logic              vld_rd;
  logic [7:0]        flags;
  logic [CW-1:0]     kb_cnt;
  logic [CW-1:0]     cs_cnt;

  logic              is_kb;
  logic              is_cs;
  logic              in_range;
  logic              upd;
  logic [IDW-1:0]    addr;
  logic [1:0]        cur;
  logic [1:0]        wr_word;
  logic              was;
  logic [7:0]        ev;
  logic [7:0]        flags_next;
  logic              irq;
  logic              chg;
  logic              clr_all;
  logic [CW-1:0]     kb_cnt_next;
  logic [CW-1:0]     cs_cnt_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  assign is_kb    = (req_q.hid_page == PAGE_KEYBOARD);
  assign is_cs    = (req_q.hid_page == PAGE_CONSUMER);
  assign in_range = (req_q.hid_code < 16'(USAGES_PER_PAGE));
  assign upd      = (req_q.req_type == REQ_UPDATE) && (is_kb || is_cs) && in_range;
  assign addr     = req_q.hid_code[IDW-1:0];
  assign cur      = vld_rd ? key_rd : 2'b00;
  assign was      = is_cs ? cur[1] : cur[0];
  assign wr_word  = is_cs ? {req_q.key_down, cur[0]} : {cur[1], req_q.key_down};

  // Entries not written since the last clear read as released.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      key_rd <= key_ram[addr];
      vld_rd <= key_valid[addr];
    end
    if (cmd.update && upd) begin
      key_ram[addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= '0;
    end else if (cmd.update && clr_all) begin
      key_valid <= '0;
    end else if (cmd.update && upd) begin
      key_valid[addr] <= 1'b1;
    end
  end

  always_comb begin
    ev          = '0;
    flags_next  = flags;
    irq         = 1'b0;
    chg         = 1'b0;
    clr_all     = 1'b0;
    kb_cnt_next = kb_cnt;
    cs_cnt_next = cs_cnt;
    case (req_q.req_type)
      REQ_UPDATE: begin
        if (upd && (was != req_q.key_down)) begin
          chg = 1'b1;
          if (is_cs) begin
            ev          = req_q.key_down ? EV_CONS_DOWN : EV_CONS_UP;
            cs_cnt_next = req_q.key_down ? cs_cnt + CW'(1) : cs_cnt - CW'(1);
          end else begin
            ev          = req_q.key_down ? EV_KEY_DOWN : EV_KEY_UP;
            kb_cnt_next = req_q.key_down ? kb_cnt + CW'(1) : kb_cnt - CW'(1);
          end
        end
      end
      REQ_ACK: begin
        flags_next = flags & ~req_q.ack_bits;
        irq        = |(flags_next & event_mask);
      end
      REQ_CLEAR: begin
        clr_all     = 1'b1;
        chg         = (kb_cnt != '0) || (cs_cnt != '0);
        kb_cnt_next = '0;
        cs_cnt_next = '0;
        if (req_q.up_on_clear) begin
          if (kb_cnt != '0) begin
            ev = ev | EV_KEY_UP;
          end
          if (cs_cnt != '0) begin
            ev = ev | EV_CONS_UP;
          end
        end
      end
      default: begin
        chg = 1'b0;
      end
    endcase
    if (ev != '0) begin
      flags_next = flags | ev;
      irq        = |(flags_next & event_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags  <= '0;
      kb_cnt <= '0;
      cs_cnt <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        flags  <= flags_next;
        kb_cnt <= kb_cnt_next;
        cs_cnt <= cs_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.event_flags       <= flags_next;
      result.irq_set           <= irq;
      result.state_changed     <= chg;
      result.any_key_held      <= (kb_cnt_next != '0);
      result.any_consumer_held <= (cs_cnt_next != '0);
    end
  end

`ifndef ASSERT_OFF
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.update))
    else $error("result strobe without a preceding update cycle");

  a_irq_masked: assert property (@(posedge clk) disable iff (rst)
    (done && result.irq_set) |-> ((result.event_flags & $past(event_mask)) != '0))
    else $error("interrupt raised with no enabled flag set");

  a_upper_flags_zero: assert property (@(posedge clk) disable iff (rst)
    flags[7:4] == 4'd0)
    else $error("event flag bits above bit 3 were set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (kb_cnt <= CW'(USAGES_PER_PAGE)) && (cs_cnt <= CW'(USAGES_PER_PAGE)))
    else $error("held key count exceeds page size");
`endif

endmodule

// ----- design/hid_key_event_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// hid_key_event_tracker_unit
// Tracks held keyboard and consumer usages and raises sticky event flags
// with a masked interrupt request; event mask set through an APB port.
// ----------------------------------------------------------------------------
// The request is captured at the accepting edge, the key memory is read in
// ST_READ and written back in ST_UPDATE, and done and result are registered
// from ST_UPDATE. A new request is taken only once that write-back is done;
// busy is high meanwhile. Results are shown for one cycle and cannot be stalled.
// Reset clears all held keys (valid bits), counters, flags and event_mask.
module hid_key_event_tracker_unit #(
  parameter int USAGES_PER_PAGE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  hket_pkg::hket_req_t               req,
  output logic                              done,
  output hket_pkg::hket_res_t               result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hket_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import hket_pkg::*;

  hket_cmd_t  cmd;
  logic [7:0] event_mask;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_mask <= '0;
    end else if (psel && penable && pwrite && (paddr == ADDR_EVENT_MASK)) begin
      event_mask <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == ADDR_EVENT_MASK) ? {24'd0, event_mask} : 32'd0;

  hket_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  hket_dpath #(
    .USAGES_PER_PAGE (USAGES_PER_PAGE)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req        (req),
    .event_mask (event_mask),
    .done       (done),
    .result     (result)
  );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HID key event tracker. Requests go in through
// the start/busy handshake and the event mask through the APB port. A
// scoreboard keeps its own copy of both key bitmaps, the sticky flags and the
// mask, predicts every result and compares each done strobe field by field.
// ----------------------------------------------------------------------------
module tb;
  import hket_pkg::*;

  localparam int KEY_SLOTS = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 250;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Mirrors the tracker state and holds the results it still owes.
  class key_event_scoreboard;
    logic [KEY_SLOTS-1:0] keyboard_map;
    logic [KEY_SLOTS-1:0] consumer_map;
    logic [7:0] flags;
    logic [7:0] mask;
    hket_res_t owed_results[$];
    int errors;

    function void set_mask(logic [7:0] value);
      mask = value;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("%0t error: %s got %h want %h", $realtime, what, got, want);
    endtask

    // Sticky OR of new events; the interrupt is only considered when some
    // event was actually raised.
    function logic raise_events(logic [7:0] ev);
      if (ev == 8'h00) return 1'b0;
      flags = flags | ev;
      return |(flags & mask);
    endfunction

    function void take_request(hket_req_t r);
      hket_res_t e;
      logic [7:0] ev;
      logic was;
      logic kb_any;
      logic cs_any;
      e = '0;
      ev = 8'h00;
      case (r.req_type)
        REQ_UPDATE: begin
          if (r.hid_code < KEY_SLOTS) begin
            if (r.hid_page == PAGE_KEYBOARD) begin
              was = keyboard_map[r.hid_code];
              keyboard_map[r.hid_code] = r.key_down;
              ev = r.key_down ? EV_KEY_DOWN : EV_KEY_UP;
            end else if (r.hid_page == PAGE_CONSUMER) begin
              was = consumer_map[r.hid_code];
              consumer_map[r.hid_code] = r.key_down;
              ev = r.key_down ? EV_CONS_DOWN : EV_CONS_UP;
            end
            if (ev != 8'h00 && was != r.key_down) begin
              e.state_changed = 1'b1;
              e.irq_set = raise_events(ev);
            end
          end
        end
        REQ_ACK: begin
          flags = flags & ~r.ack_bits;
          e.irq_set = |(flags & mask);
        end
        REQ_CLEAR: begin
          kb_any = |keyboard_map;
          cs_any = |consumer_map;
          if (r.up_on_clear) begin
            if (kb_any) ev = ev | EV_KEY_UP;
            if (cs_any) ev = ev | EV_CONS_UP;
          end
          e.state_changed = kb_any | cs_any;
          keyboard_map = '0;
          consumer_map = '0;
          e.irq_set = raise_events(ev);
        end
        default: begin
        end
      endcase
      e.event_flags = flags;
      e.any_key_held = |keyboard_map;
      e.any_consumer_held = |consumer_map;
      owed_results.push_back(e);
    endfunction

    task match_result(hket_res_t got);
      hket_res_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, event_flags", got.event_flags, 8'h00);
        return;
      end
      want = owed_results.pop_front();
      if (got.event_flags !== want.event_flags)
        report_mismatch("event_flags", got.event_flags, want.event_flags);
      if (got.irq_set !== want.irq_set)
        report_mismatch("irq_set", 8'(got.irq_set), 8'(want.irq_set));
      if (got.state_changed !== want.state_changed)
        report_mismatch("state_changed", 8'(got.state_changed),
                        8'(want.state_changed));
      if (got.any_key_held !== want.any_key_held)
        report_mismatch("any_key_held", 8'(got.any_key_held),
                        8'(want.any_key_held));
      if (got.any_consumer_held !== want.any_consumer_held)
        report_mismatch("any_consumer_held", 8'(got.any_consumer_held),
                        8'(want.any_consumer_held));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  hket_req_t req = '0;
  logic done;
  hket_res_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  key_event_scoreboard sb = new();
  int taken_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  hid_key_event_tracker_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Results are checked before the request of the same edge is noted, so the
  // oldest expectation is always the one matched.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.match_result(result);
      if (start && !busy) begin
        sb.take_request(req);
        taken_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hid_key_event_tracker_unit: mismatch");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input hket_req_t r);
    int target;
    while (idle_on && $urandom_range(0, 99) < 25) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    req = r;
    target = taken_count + 1;
    do @(negedge clk); while (taken_count < target);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_event_mask(input logic [7:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_EVENT_MASK;
    pwdata = {24'h0, value};
    @(negedge clk);
    penable = 1'b1;
    while (!pready) @(negedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_mask(value);
  endtask

  function automatic hket_req_t make_request(logic [1:0] kind, logic [15:0] page,
                                             logic [15:0] id, logic down,
                                             logic [7:0] ack, logic publish);
    hket_req_t r;
    r.req_type = kind;
    r.hid_page = page;
    r.hid_code = id;
    r.key_down = down;
    r.ack_bits = ack;
    r.up_on_clear = publish;
    return r;
  endfunction

  // Mostly updates on a few ids of the two tracked pages, so presses,
  // releases and repeats all happen; the rest is acks, clears and noise.
  function automatic hket_req_t random_request();
    hket_req_t r;
    int pick;
    r = make_request(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                     8'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      r.req_type = REQ_UPDATE;
      if ($urandom_range(0, 9) != 0)
        r.hid_page = $urandom_range(0, 1) ? PAGE_KEYBOARD : PAGE_CONSUMER;
      case ($urandom_range(0, 9))
        0: ;
        1, 2: r.hid_code = 16'($urandom_range(0, KEY_SLOTS - 1));
        3: r.hid_code = 16'(KEY_SLOTS - 1 - $urandom_range(0, 3));
        default: r.hid_code = 16'($urandom_range(0, 7));
      endcase
    end else if (pick < 88) begin
      r.req_type = REQ_ACK;
    end else if (pick < 96) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  initial begin
    hket_req_t directed[$];
    logic [7:0] phase_masks[5];
    phase_masks = '{8'h00, 8'hFF, 8'($urandom), 8'h0C, 8'h03};

    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd0, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd0, 1'b1, 8'hFF, 1'b1));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd255, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_CONSUMER, 16'd255, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_CONSUMER, 16'd0, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, 16'h0008, 16'd5, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, 16'hFFFF, 16'd5, 1'b1, 8'hFF, 1'b1));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd256, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_CONSUMER, 16'hFFFF, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd0, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd0, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_CONSUMER, 16'd0, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_ACK, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_ACK, 16'hFFFF, 16'hFFFF, 1'b1, 8'h05, 1'b1));
    directed.push_back(make_request(REQ_ACK, 16'h0000, 16'h0000, 1'b0, 8'hFF, 1'b0));
    directed.push_back(make_request(REQ_CLEAR, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1));
    directed.push_back(make_request(REQ_CLEAR, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd17, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_CONSUMER, 16'd200, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_ACK, 16'h0000, 16'h0000, 1'b0, 8'hFF, 1'b0));
    directed.push_back(make_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b0));
    directed.push_back(make_request(REQ_UPDATE, PAGE_KEYBOARD, 16'd3, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_UNUSED, PAGE_KEYBOARD, 16'd3, 1'b0, 8'hFF, 1'b1));
    directed.push_back(make_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1));

    repeat (6) @(negedge clk);
    rst = 1'b0;

    write_event_mask(8'hFF);
    foreach (directed[i]) send_request(directed[i]);
    drain_results();

    foreach (phase_masks[p]) begin
      write_event_mask(phase_masks[p]);
      idle_on = (p != 2);
      repeat (RANDOM_PER_PHASE) send_request(random_request());
      drain_results();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hid_key_event_tracker_unit: match");
    end else begin
      $display("hid_key_event_tracker_unit: mismatch");
    end
    $finish;
  end

endmodule
